/* rtl/rgbb_pkg.sv */
// shared constants, types and helpers for the rotated rgb565 blitter
`timescale 1ns / 1ps
`default_nettype none

package rgbb_pkg;

  localparam int unsigned FRAME_WORDS = 1048576;
  localparam int unsigned MAX_SIDE    = 2048;

  localparam int COORD_W  = 11;
  localparam int CHAN_W   = 8;
  localparam int REG_W    = 12;
  localparam int PIX_W    = 16;
  localparam int WADDR_W  = 20;
  localparam int STATUS_W = 2;

  localparam int MEM_AW  = $clog2(FRAME_WORDS);
  localparam int PROD_W  = COORD_W + REG_W;
  localparam int SUM_W   = (MEM_AW > PROD_W) ? MEM_AW : PROD_W;

  localparam int NUM_REGS  = 6;
  localparam int PADDR_W   = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam int PDATA_W   = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROTATION,
    REG_LINE_PITCH,
    REG_PANEL_WIDTH,
    REG_PANEL_HEIGHT,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLIPPED,
    ST_SAME,
    ST_WRITTEN,
    ST_BEYOND
  } status_t;

  // effective geometry, already limited to the largest side
  typedef struct packed {
    logic [1:0]       rotation;
    logic [REG_W-1:0] line_pitch;
    logic [REG_W-1:0] panel_width;
    logic [REG_W-1:0] panel_height;
    logic [REG_W-1:0] image_width;
    logic [REG_W-1:0] image_height;
  } cfg_t;

  function automatic logic [REG_W-1:0] side_clamp(input logic [REG_W-1:0] v);
    side_clamp = (32'(v) > MAX_SIDE) ? REG_W'(MAX_SIDE) : v;
  endfunction

endpackage

`default_nettype wire

/* rtl/rgbb_if.sv */
// pixel input and result output channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface rgbb_in_if import rgbb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  logic               end_of_image;

  modport source (output valid, column, row, red, green, blue, end_of_image, input ready);
  modport sink (input valid, column, row, red, green, blue, end_of_image, output ready);
endinterface

interface rgbb_out_if import rgbb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WADDR_W-1:0]  word_address;
  logic [PIX_W-1:0]    packed_pixel;
  logic [STATUS_W-1:0] status;
  logic                dirty;

  modport source (output valid, word_address, packed_pixel, status, dirty, input ready);
  modport sink (input valid, word_address, packed_pixel, status, dirty, output ready);
endinterface

`default_nettype wire

/* rtl/rotated_rgb565_blit_with_dirty.sv */
// a pixel passes stages s1, s2, s3 and the output register before its result shows
// one pixel per cycle unless stalled; read-compare-write, single-port-write frame ram
// a write still in flight is forwarded to the read that follows it on the same word
// reset clears control state and then sweeps the frame ram to zero, one word a cycle;
// no pixel is taken until the sweep ends; register writes still work
`timescale 1ns / 1ps
`default_nettype none

module rotated_rgb565_blit_with_dirty import rgbb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  rgbb_in_if.sink                 pix_in,
  rgbb_out_if.source              pix_out
);

  localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(FRAME_WORDS - 1);

  cfg_t cfg;

  rgbb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [PIX_W-1:0] frame_mem [FRAME_WORDS];

  logic              clr_active;
  logic [MEM_AW-1:0] clr_idx;
  logic              dirty_flag;
  logic              o_valid;
  logic              adv;
  logic              accept;

  // geometry at the input
  logic [REG_W-1:0]   xres, yres, xlim, ylim;
  logic [COORD_W-1:0] x_rev, y_rev;
  logic [COORD_W-1:0] op_a, op_c;
  logic               clip_in;
  logic [PIX_W-1:0]   pix_in_packed;

  logic               s1_valid, s2_valid, s3_valid;
  logic [COORD_W-1:0] s1_a, s1_c, s2_c;
  logic [REG_W-1:0]   s1_lp;
  logic               s1_clip, s2_clip, s3_clip;
  logic [PIX_W-1:0]   s1_pix, s2_pix, s3_pix;
  logic               s1_eoi, s2_eoi, s3_eoi;
  logic [PROD_W-1:0]  s2_prod;
  logic [SUM_W-1:0]   s2_sum, s3_sum;
  logic               s3_beyond;
  logic               s3_fwd;
  logic [PIX_W-1:0]   s3_fwd_data;
  logic [PIX_W-1:0]   rd_data;
  logic [PIX_W-1:0]   s3_stored;
  status_t            s3_status;
  logic               s3_write;
  logic               dirty_now;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa;
  logic [PIX_W-1:0]  mem_wd;

  // whole pipe moves together whenever the output register can take a result
  assign adv          = !o_valid || pix_out.ready;
  assign pix_in.ready = adv && !clr_active;
  assign accept       = pix_in.valid && pix_in.ready;
  assign pix_out.valid = o_valid;

  always_comb begin
    // odd rotations keep the panel axes, even ones swap them
    xres = cfg.rotation[0] ? cfg.panel_width  : cfg.panel_height;
    yres = cfg.rotation[0] ? cfg.panel_height : cfg.panel_width;
    xlim = (cfg.image_width  < xres) ? cfg.image_width  : xres;
    ylim = (cfg.image_height < yres) ? cfg.image_height : yres;
    clip_in = ({1'b0, pix_in.column} >= xlim) || ({1'b0, pix_in.row} >= ylim);
    x_rev = COORD_W'(xres - REG_W'(1) - {1'b0, pix_in.column});
    y_rev = COORD_W'(yres - REG_W'(1) - {1'b0, pix_in.row});
    case (cfg.rotation)
      2'd0: begin
        op_a = pix_in.column;
        op_c = y_rev;
      end
      2'd1: begin
        op_a = pix_in.row;
        op_c = pix_in.column;
      end
      2'd2: begin
        op_a = x_rev;
        op_c = pix_in.row;
      end
      default: begin
        op_a = y_rev;
        op_c = x_rev;
      end
    endcase
    pix_in_packed = {pix_in.red[7:3], pix_in.green[7:2], pix_in.blue[7:3]};
  end

  assign s2_sum = SUM_W'(s2_prod) + SUM_W'(s2_c);

  always_comb begin
    s3_stored = s3_fwd ? s3_fwd_data : rd_data;
    if (s3_clip) begin
      s3_status = ST_CLIPPED;
    end else if (s3_beyond) begin
      s3_status = ST_BEYOND;
    end else if (s3_stored == s3_pix) begin
      s3_status = ST_SAME;
    end else begin
      s3_status = ST_WRITTEN;
    end
    s3_write  = s3_valid && (s3_status == ST_WRITTEN);
    dirty_now = dirty_flag || s3_write;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      o_valid    <= 1'b0;
      dirty_flag <= 1'b0;
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else begin
      if (clr_active) begin
        clr_idx <= clr_idx + MEM_AW'(1);
        if (clr_idx == CLR_LAST) begin
          clr_active <= 1'b0;
        end
      end
      if (adv) begin
        s1_valid <= accept;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
        o_valid  <= s3_valid;
        if (s3_valid) begin
          dirty_flag <= s3_eoi ? 1'b0 : dirty_now;
        end
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a    <= op_a;
      s1_c    <= op_c;
      s1_lp   <= cfg.line_pitch;
      s1_clip <= clip_in;
      s1_pix  <= pix_in_packed;
      s1_eoi  <= pix_in.end_of_image;

      s2_prod <= PROD_W'(s1_a) * PROD_W'(s1_lp);
      s2_c    <= s1_c;
      s2_clip <= s1_clip;
      s2_pix  <= s1_pix;
      s2_eoi  <= s1_eoi;

      s3_sum      <= s2_sum;
      s3_beyond   <= 32'(s2_sum) >= FRAME_WORDS;
      s3_clip     <= s2_clip;
      s3_pix      <= s2_pix;
      s3_eoi      <= s2_eoi;
      // the word read now misses the write landing at this same edge
      s3_fwd      <= s3_write && (s3_sum == s2_sum);
      s3_fwd_data <= s3_pix;

      if (s3_valid) begin
        pix_out.word_address <= s3_clip ? '0 : WADDR_W'(s3_sum);
        pix_out.packed_pixel <= s3_pix;
        pix_out.status       <= s3_status;
        pix_out.dirty        <= dirty_now;
      end
    end
  end

  assign mem_we = clr_active || (adv && s3_write);
  assign mem_wa = clr_active ? clr_idx : s3_sum[MEM_AW-1:0];
  assign mem_wd = clr_active ? '0 : s3_pix;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= frame_mem[s2_sum[MEM_AW-1:0]];
    end
  end

endmodule

`default_nettype wire

/* rtl/rgbb_cfg.sv */
// apb register bank holding rotation and geometry settings
`timescale 1ns / 1ps
`default_nettype none

module rgbb_cfg import rgbb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic [1:0]       rotation;
  logic [REG_W-1:0] line_pitch;
  logic [REG_W-1:0] panel_width;
  logic [REG_W-1:0] panel_height;
  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation     <= 2'd0;
      line_pitch   <= REG_W'(1024);
      panel_width  <= REG_W'(1024);
      panel_height <= REG_W'(768);
      image_width  <= '0;
      image_height <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_ROTATION:     rotation     <= pwdata[1:0];
        REG_LINE_PITCH:   line_pitch   <= pwdata[REG_W-1:0];
        REG_PANEL_WIDTH:  panel_width  <= pwdata[REG_W-1:0];
        REG_PANEL_HEIGHT: panel_height <= pwdata[REG_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROTATION:     prdata = PDATA_W'(rotation);
      REG_LINE_PITCH:   prdata = PDATA_W'(line_pitch);
      REG_PANEL_WIDTH:  prdata = PDATA_W'(panel_width);
      REG_PANEL_HEIGHT: prdata = PDATA_W'(panel_height);
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  assign cfg.rotation     = rotation;
  assign cfg.line_pitch   = side_clamp(line_pitch);
  assign cfg.panel_width  = side_clamp(panel_width);
  assign cfg.panel_height = side_clamp(panel_height);
  assign cfg.image_width  = side_clamp(image_width);
  assign cfg.image_height = side_clamp(image_height);

endmodule

`default_nettype wire

/* verif/blit_checker.sv */
// checker for the rotated rgb565 blitter: mirrors the registers and frame store, compares results
`timescale 1ns / 1ps

module blit_checker import rgbb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic               pready,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  rgbb_in_if                      pix_in,
  rgbb_out_if                     pix_out,
  output int unsigned             outstanding,
  output int unsigned             mismatches,
  output int unsigned             status_tally [4]
);

  localparam logic [1:0] ROT0 = 2'd0;
  localparam logic [1:0] ROT1 = 2'd1;
  localparam logic [1:0] ROT2 = 2'd2;

  typedef struct packed {
    logic [WADDR_W-1:0] word_address;
    logic [PIX_W-1:0]   packed_pixel;
    status_t            status;
    logic               dirty;
  } blit_outcome_t;

  logic [1:0]       rot_r;
  logic [REG_W-1:0] pitch_r;
  logic [REG_W-1:0] pan_w_r;
  logic [REG_W-1:0] pan_h_r;
  logic [REG_W-1:0] img_w_r;
  logic [REG_W-1:0] img_h_r;
  logic             dirty_r;

  // only words written since reset are held, the rest read as zero
  logic [PIX_W-1:0] fb_mirror [int unsigned];
  blit_outcome_t    blit_outcomes [$];

  function automatic longint unsigned limit_side(input logic [REG_W-1:0] v);
    return (v > MAX_SIDE) ? longint'(MAX_SIDE) : longint'(v);
  endfunction

  function automatic blit_outcome_t blit_pixel(input logic [COORD_W-1:0] col,
                                               input logic [COORD_W-1:0] row,
                                               input logic [CHAN_W-1:0] r,
                                               input logic [CHAN_W-1:0] g,
                                               input logic [CHAN_W-1:0] b,
                                               input logic eoi);
    longint unsigned x, y, xres, yres, lp, win_x, win_y, addr;
    logic [PIX_W-1:0] stored;
    blit_outcome_t    res;
    x = longint'(col);
    y = longint'(row);
    res.packed_pixel = {r[7:3], g[7:2], b[7:3]};
    // even rotations swap the panel sides
    if (rot_r[0]) begin
      xres = limit_side(pan_w_r);
      yres = limit_side(pan_h_r);
    end else begin
      xres = limit_side(pan_h_r);
      yres = limit_side(pan_w_r);
    end
    lp = limit_side(pitch_r);
    win_x = (limit_side(img_w_r) < xres) ? limit_side(img_w_r) : xres;
    win_y = (limit_side(img_h_r) < yres) ? limit_side(img_h_r) : yres;
    addr = 0;
    if (x >= win_x || y >= win_y) begin
      res.status = ST_CLIPPED;
    end else begin
      case (rot_r)
        ROT0:    addr = x * lp + (yres - 1 - y);
        ROT1:    addr = y * lp + x;
        ROT2:    addr = (xres - 1 - x) * lp + y;
        default: addr = (yres - 1 - y) * lp + (xres - 1 - x);
      endcase
      if (addr >= longint'(FRAME_WORDS)) begin
        res.status = ST_BEYOND;
      end else begin
        stored = fb_mirror.exists(int'(addr)) ? fb_mirror[int'(addr)] : '0;
        if (stored == res.packed_pixel) begin
          res.status = ST_SAME;
        end else begin
          fb_mirror[int'(addr)] = res.packed_pixel;
          dirty_r = 1'b1;
          res.status = ST_WRITTEN;
        end
      end
    end
    res.word_address = addr[WADDR_W-1:0];
    res.dirty = dirty_r;
    if (eoi) dirty_r = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    blit_outcome_t want;
    if (rst) begin
      rot_r = 2'd0;
      pitch_r = REG_W'(1024);
      pan_w_r = REG_W'(1024);
      pan_h_r = REG_W'(768);
      img_w_r = '0;
      img_h_r = '0;
      dirty_r = 1'b0;
      fb_mirror.delete();
      blit_outcomes.delete();
      outstanding = 0;
      mismatches = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[PADDR_W-1:2]))
          REG_ROTATION:     rot_r = pwdata[1:0];
          REG_LINE_PITCH:   pitch_r = pwdata[REG_W-1:0];
          REG_PANEL_WIDTH:  pan_w_r = pwdata[REG_W-1:0];
          REG_PANEL_HEIGHT: pan_h_r = pwdata[REG_W-1:0];
          REG_IMAGE_WIDTH:  img_w_r = pwdata[REG_W-1:0];
          REG_IMAGE_HEIGHT: img_h_r = pwdata[REG_W-1:0];
          default: ;
        endcase
      end
      if (pix_out.valid && pix_out.ready) begin
        if (blit_outcomes.size() == 0) begin
          $error("result transaction with no pixel pending: word_address %0h",
                 pix_out.word_address);
          mismatches++;
        end else begin
          want = blit_outcomes.pop_front();
          status_tally[want.status]++;
          if (pix_out.word_address !== want.word_address) begin
            $error("word_address: expected %0h, actual %0h", want.word_address,
                   pix_out.word_address);
            mismatches++;
          end
          if (pix_out.packed_pixel !== want.packed_pixel) begin
            $error("packed_pixel: expected %0h, actual %0h", want.packed_pixel,
                   pix_out.packed_pixel);
            mismatches++;
          end
          if (pix_out.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, pix_out.status);
            mismatches++;
          end
          if (pix_out.dirty !== want.dirty) begin
            $error("dirty: expected %0b, actual %0b", want.dirty, pix_out.dirty);
            mismatches++;
          end
        end
      end
      if (pix_in.valid && pix_in.ready) begin
        blit_outcomes.push_back(blit_pixel(pix_in.column, pix_in.row, pix_in.red,
                                           pix_in.green, pix_in.blue, pix_in.end_of_image));
      end
      outstanding = blit_outcomes.size();
    end
  end

endmodule

/* verif/testbench.sv */
// top of the blitter testbench: clock, reset, register writes and pixel stimulus
`timescale 1ns / 1ps

module testbench;
  import rgbb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_PIXELS = 66;
  localparam logic [REG_W-1:0] REG_ALL_ONES = '1;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  rgbb_in_if  pix_in_bus ();
  rgbb_out_if pix_out_bus ();

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned status_tally [4];

  int unsigned cycle_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned settings_used = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  logic [REG_W-1:0]     cfg_shadow [NUM_REGS];
  logic [2*COORD_W-1:0] recent_spots [$];

  rotated_rgb565_blit_with_dirty dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_in  (pix_in_bus),
    .pix_out (pix_out_bus)
  );

  blit_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pix_in       (pix_in_bus),
    .pix_out      (pix_out_bus),
    .outstanding  (outstanding),
    .mismatches   (mismatches),
    .status_tally (status_tally)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    pix_out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    cfg_shadow[idx] = value;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    pix_in_bus.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic set_geometry(input logic [1:0] rot, input logic [REG_W-1:0] pitch,
                              input logic [REG_W-1:0] pan_w, input logic [REG_W-1:0] pan_h,
                              input logic [REG_W-1:0] img_w, input logic [REG_W-1:0] img_h);
    wait_drain();
    write_reg(REG_ROTATION, REG_W'(rot));
    write_reg(REG_LINE_PITCH, pitch);
    write_reg(REG_PANEL_WIDTH, pan_w);
    write_reg(REG_PANEL_HEIGHT, pan_h);
    write_reg(REG_IMAGE_WIDTH, img_w);
    write_reg(REG_IMAGE_HEIGHT, img_h);
    recent_spots.delete();
    settings_used++;
  endtask

  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                            input logic [23:0] rgb, input logic eoi);
    while ($urandom_range(0, 99) < idle_pct) begin
      pix_in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in_bus.valid <= 1'b1;
    pix_in_bus.column <= col;
    pix_in_bus.row <= row;
    pix_in_bus.red <= rgb[23:16];
    pix_in_bus.green <= rgb[15:8];
    pix_in_bus.blue <= rgb[7:0];
    pix_in_bus.end_of_image <= eoi;
    do @(posedge clk); while (!pix_in_bus.ready);
    @(negedge clk);
    pixels_sent++;
  endtask

  function automatic int unsigned clip_extent(input logic [REG_W-1:0] img,
                                              input logic [REG_W-1:0] panel);
    int unsigned a, b;
    a = (img > MAX_SIDE) ? MAX_SIDE : img;
    b = (panel > MAX_SIDE) ? MAX_SIDE : panel;
    return (a < b) ? a : b;
  endfunction

  // four times in ten one of a handful of shades, so that repeated writes often match the stored word
  function automatic logic [23:0] pick_colour();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h804020;
      3: return 24'h070307;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_extent(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 19))
      0, 1: return REG_ALL_ONES;
      2:    return REG_W'(MAX_SIDE);
      default: return REG_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // one image: pixels inside the visible window, some revisited, a little noise, eoi last and now and then on noise
  task automatic draw_image(input int count);
    int unsigned          win_x, win_y;
    logic [COORD_W-1:0]   col, row;
    logic [2*COORD_W-1:0] spot;
    logic                 eoi;
    logic                 panel_x_sel;
    panel_x_sel = cfg_shadow[REG_ROTATION][0];
    win_x = clip_extent(cfg_shadow[REG_IMAGE_WIDTH],
                        panel_x_sel ? cfg_shadow[REG_PANEL_WIDTH] : cfg_shadow[REG_PANEL_HEIGHT]);
    win_y = clip_extent(cfg_shadow[REG_IMAGE_HEIGHT],
                        panel_x_sel ? cfg_shadow[REG_PANEL_HEIGHT] : cfg_shadow[REG_PANEL_WIDTH]);
    for (int i = 0; i < count; i++) begin
      eoi = (i == count - 1);
      if (win_x == 0 || win_y == 0 || $urandom_range(0, 99) < 15) begin
        col = COORD_W'($urandom);
        row = COORD_W'($urandom);
        if ($urandom_range(0, 9) == 0) eoi = 1'b1;
        send_pixel(col, row, 24'($urandom), eoi);
      end else begin
        if (recent_spots.size() != 0 && $urandom_range(0, 99) < 35) begin
          spot = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
        end else begin
          spot = {COORD_W'($urandom_range(0, win_x - 1)), COORD_W'($urandom_range(0, win_y - 1))};
          recent_spots.push_back(spot);
          if (recent_spots.size() > 8) void'(recent_spots.pop_front());
        end
        send_pixel(spot[2*COORD_W-1:COORD_W], spot[COORD_W-1:0], pick_colour(), eoi);
      end
    end
  endtask

  initial begin
    int count, phase_sent;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_in_bus.valid = 1'b0;
    pix_in_bus.column = '0;
    pix_in_bus.row = '0;
    pix_in_bus.red = '0;
    pix_in_bus.green = '0;
    pix_in_bus.blue = '0;
    pix_in_bus.end_of_image = 1'b0;
    pix_out_bus.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // rotation 0 mapping, oversized image width, short image height
    set_geometry(2'd0, 12'd512, 12'd512, 12'd512, REG_ALL_ONES, 12'd300);
    send_pixel(11'd0, 11'd0, 24'hFFFFFF, 1'b0);
    send_pixel(11'd0, 11'd0, 24'hFFFFFF, 1'b0);
    send_pixel(11'd0, 11'd0, 24'h000000, 1'b0);
    send_pixel(11'd511, 11'd299, 24'h000000, 1'b0);
    send_pixel(11'd511, 11'd299, 24'hFF0000, 1'b0);
    send_pixel(11'd512, 11'd0, 24'h00FF00, 1'b0);
    send_pixel(11'd0, 11'd300, 24'h0000FF, 1'b0);
    send_pixel(11'd2047, 11'd2047, 24'hFFFFFF, 1'b0);
    // low colour bits are dropped by the packing
    send_pixel(11'd10, 11'd10, 24'h070307, 1'b0);
    send_pixel(11'd10, 11'd10, 24'h080408, 1'b1);
    send_pixel(11'd20, 11'd20, 24'h000000, 1'b1);
    send_pixel(11'd900, 11'd5, 24'h123456, 1'b1);

    // full-size panel, addresses run past the end of the store
    set_geometry(2'd1, 12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
    send_pixel(11'd2047, 11'd2047, 24'hA5A5A5, 1'b0);
    send_pixel(11'd5, 11'd511, 24'h5A5A5A, 1'b0);
    send_pixel(11'd0, 11'd512, 24'hFFFFFF, 1'b0);
    send_pixel(11'd100, 11'd1000, 24'h336699, 1'b1);

    set_geometry(2'd2, 12'd64, 12'd100, 12'd50, 12'd80, REG_ALL_ONES);
    send_pixel(11'd0, 11'd0, 24'hC0C0C0, 1'b0);
    send_pixel(11'd49, 11'd99, 24'h102030, 1'b0);
    send_pixel(11'd50, 11'd0, 24'h405060, 1'b1);

    // zero pitch with an oversized panel side
    set_geometry(2'd3, 12'd0, 12'd3000, 12'd16, 12'd10, 12'd10);
    send_pixel(11'd0, 11'd0, 24'hFF00FF, 1'b0);
    send_pixel(11'd9, 11'd9, 24'h00FFFF, 1'b0);
    send_pixel(11'd10, 11'd0, 24'hFFFF00, 1'b1);

    // empty image clips everything
    set_geometry(2'd1, 12'd1, 12'd1, 12'd1, 12'd0, 12'd0);
    send_pixel(11'd0, 11'd0, 24'hFFFFFF, 1'b1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      if (phase == 0)
        set_geometry(2'd3, REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES);
      else if (phase == 1)
        set_geometry(2'd2, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1);
      else
        set_geometry(2'(phase), pick_extent(1, 700), pick_extent(1, 600), pick_extent(1, 600),
                     pick_extent(1, 700), pick_extent(1, 700));
      phase_sent = 0;
      while (phase_sent < PHASE_PIXELS) begin
        count = $urandom_range(4, 20);
        if (count > PHASE_PIXELS - phase_sent) count = PHASE_PIXELS - phase_sent;
        draw_image(count);
        // let the pipeline run dry once per phase
        if (phase_sent == 0) wait_drain();
        phase_sent += count;
      end
    end

    wait_drain();
    repeat (10) @(negedge clk);
    $display("covered %0d pixels over %0d register settings, four idle/stall mixes",
             pixels_sent, settings_used);
    $display("outcomes: %0d clipped, %0d unchanged, %0d written, %0d beyond store",
             status_tally[ST_CLIPPED], status_tally[ST_SAME], status_tally[ST_WRITTEN],
             status_tally[ST_BEYOND]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rgbb_pkg.sv
rtl/rgbb_if.sv
rtl/rgbb_cfg.sv
rtl/rotated_rgb565_blit_with_dirty.sv
verif/blit_checker.sv
verif/testbench.sv
